[rtl/ssr_pkg.sv]
// Shared types, codes and defaults of the Shamir secret reconstruction block.
package ssr_pkg;

  localparam int MAX_SHARES_DEF = 16;
  localparam int FIELD_BITS_DEF = 31;
  localparam logic [63:0] MODULUS_RESET = 64'd2147483647;

  // result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DUP  = 2'd1;
  localparam logic [1:0] STATUS_OVER = 2'd2;

  // multiplier operand sources
  typedef enum logic [3:0] {
    OP_ONE, OP_IN_X, OP_IN_Y, OP_XJ, OP_DIFF, OP_NUM, OP_DEN, OP_R, OP_BASE, OP_YI
  } operand_e;

  // multiplier result destinations
  typedef enum logic [2:0] {
    DST_NONE, DST_MEM_X, DST_MEM_Y, DST_NUM, DST_DEN, DST_R, DST_BASE, DST_T
  } dest_e;

  // controller to datapath commands
  typedef struct packed {
    logic       cap_in;
    logic       mul_start;
    operand_e   opa;
    operand_e   opb;
    dest_e      wr_dst;
    logic       rd_en;
    logic       ld_xi;
    logic       ld_xj;
    logic       init_nd;
    logic       init_pow;
    logic       clr_secret;
    logic       add_secret;
    logic       load_out;
    logic [1:0] status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic mul_done;
    logic x_eq;
    logic exp_bit;
    logic is_last;
  } sts_t;

endpackage

[rtl/ssr_if.sv]
// Valid/ready channel interfaces for shares in and results out.
interface share_if #(parameter int FW = 31);
  logic          valid;
  logic          ready;
  logic [FW-1:0] share_x;
  logic [FW-1:0] share_y;
  logic          is_last;
  modport source (output valid, output share_x, output share_y, output is_last, input ready);
  modport sink (input valid, input share_x, input share_y, input is_last, output ready);
endinterface

interface result_if #(parameter int FW = 31);
  logic          valid;
  logic          ready;
  logic [FW-1:0] secret;
  logic [1:0]    status;
  modport source (output valid, output secret, output status, input ready);
  modport sink (input valid, input secret, input status, output ready);
endinterface

[rtl/ssr_mulmod.sv]
// Bit-serial modular multiplier, one bit of b per cycle, MSB first.
module ssr_mulmod #(
  parameter int FIELD_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [FIELD_BITS-1:0] a_i,
  input  logic [FIELD_BITS-1:0] b_i,
  input  logic [FIELD_BITS-1:0] m_i,
  output logic                  done_o,
  output logic [FIELD_BITS-1:0] res_o
);
  localparam int KW = $clog2(FIELD_BITS + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [KW-1:0]         cnt_q;
  logic [FIELD_BITS-1:0] acc_q, acc_d;
  logic [FIELD_BITS-1:0] a_q;
  logic [FIELD_BITS-1:0] b_q;
  logic [FIELD_BITS:0]   dbl, sum, mod_w;

  // acc = (2*acc mod m + bit*a) mod m
  always_comb begin
    mod_w = {1'b0, m_i};
    dbl   = {acc_q, 1'b0};
    if (dbl >= mod_w) dbl = dbl - mod_w;
    sum = dbl + (b_q[FIELD_BITS-1] ? {1'b0, a_q} : '0);
    if (sum >= mod_w) sum = sum - mod_w;
    acc_d = sum[FIELD_BITS-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= KW'(FIELD_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - KW'(1);
        if (cnt_q == KW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[FIELD_BITS-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;
endmodule

[rtl/ssr_datapath.sv]
// Share stores, interpolation registers and the shared modular multiplier.
module ssr_datapath #(
  parameter int MAX_SHARES = ssr_pkg::MAX_SHARES_DEF,
  parameter int FIELD_BITS = ssr_pkg::FIELD_BITS_DEF,
  localparam int AW = $clog2(MAX_SHARES),
  localparam int KIW = $clog2(FIELD_BITS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ssr_pkg::cmd_t         cmd_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [AW-1:0]         rd_addr_i,
  input  logic [KIW-1:0]        exp_idx_i,
  input  logic [FIELD_BITS-1:0] modulus_i,
  input  logic [FIELD_BITS-1:0] in_x_i,
  input  logic [FIELD_BITS-1:0] in_y_i,
  input  logic                  in_last_i,
  output ssr_pkg::sts_t         sts_o,
  output logic [FIELD_BITS-1:0] secret_o,
  output logic [1:0]            status_o
);
  import ssr_pkg::*;

  logic [FIELD_BITS-1:0] x_mem [MAX_SHARES];
  logic [FIELD_BITS-1:0] y_mem [MAX_SHARES];
  logic [FIELD_BITS-1:0] x_rd_q, y_rd_q;
  logic [FIELD_BITS-1:0] in_x_q, in_y_q;
  logic                  in_last_q;
  logic [FIELD_BITS-1:0] xi_q, yi_q, xj_q, diff_q;
  logic [FIELD_BITS-1:0] num_q, den_q, r_q, base_q, t_q, secret_q;
  logic [FIELD_BITS-1:0] out_secret_q;
  logic [1:0]            out_status_q;
  logic [FIELD_BITS-1:0] opa_v, opb_v, mul_res, diff_c, exp_v, sec_c;
  logic [FIELD_BITS:0]   sec_sum;
  logic                  mul_done;

  function automatic logic [FIELD_BITS-1:0] pick(
    input operand_e sel, input logic [FIELD_BITS-1:0] ix, input logic [FIELD_BITS-1:0] iy,
    input logic [FIELD_BITS-1:0] xj, input logic [FIELD_BITS-1:0] df,
    input logic [FIELD_BITS-1:0] nm, input logic [FIELD_BITS-1:0] dn,
    input logic [FIELD_BITS-1:0] rr, input logic [FIELD_BITS-1:0] bs,
    input logic [FIELD_BITS-1:0] yi);
    logic [FIELD_BITS-1:0] v;
    case (sel)
      OP_IN_X: v = ix;
      OP_IN_Y: v = iy;
      OP_XJ:   v = xj;
      OP_DIFF: v = df;
      OP_NUM:  v = nm;
      OP_DEN:  v = dn;
      OP_R:    v = rr;
      OP_BASE: v = bs;
      OP_YI:   v = yi;
      default: v = FIELD_BITS'(1);
    endcase
    return v;
  endfunction

  assign opa_v = pick(cmd_i.opa, in_x_q, in_y_q, xj_q, diff_q, num_q, den_q, r_q, base_q, yi_q);
  assign opb_v = pick(cmd_i.opb, in_x_q, in_y_q, xj_q, diff_q, num_q, den_q, r_q, base_q, yi_q);

  ssr_mulmod #(.FIELD_BITS(FIELD_BITS)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (opa_v),
    .b_i    (opb_v),
    .m_i    (modulus_i),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  // (xj - xi) mod m, both already reduced
  assign diff_c = (x_rd_q >= xi_q) ? x_rd_q - xi_q
                : FIELD_BITS'({1'b0, x_rd_q} + {1'b0, modulus_i} - {1'b0, xi_q});

  // running secret sum mod m
  always_comb begin
    sec_sum = {1'b0, secret_q} + {1'b0, t_q};
    if (sec_sum >= {1'b0, modulus_i}) sec_sum = sec_sum - {1'b0, modulus_i};
    sec_c = sec_sum[FIELD_BITS-1:0];
  end

  // inverse exponent m-2
  assign exp_v = modulus_i - FIELD_BITS'(2);

  // share stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_dst == DST_MEM_X) x_mem[wr_addr_i] <= mul_res;
    if (cmd_i.wr_dst == DST_MEM_Y) y_mem[wr_addr_i] <= mul_res;
    if (cmd_i.rd_en) begin
      x_rd_q <= x_mem[rd_addr_i];
      y_rd_q <= y_mem[rd_addr_i];
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      in_x_q    <= in_x_i;
      in_y_q    <= in_y_i;
      in_last_q <= in_last_i;
    end
    if (cmd_i.ld_xi) begin
      xi_q <= x_rd_q;
      yi_q <= y_rd_q;
    end
    if (cmd_i.ld_xj) begin
      xj_q   <= x_rd_q;
      diff_q <= diff_c;
    end
    if (cmd_i.init_nd) begin
      num_q <= FIELD_BITS'(1);
      den_q <= FIELD_BITS'(1);
    end
    if (cmd_i.init_pow) begin
      r_q    <= FIELD_BITS'(1);
      base_q <= den_q;
    end
    case (cmd_i.wr_dst)
      DST_NUM:  num_q  <= mul_res;
      DST_DEN:  den_q  <= mul_res;
      DST_R:    r_q    <= mul_res;
      DST_BASE: base_q <= mul_res;
      DST_T:    t_q    <= mul_res;
      default: ;
    endcase
    if (cmd_i.clr_secret) secret_q <= '0;
    else if (cmd_i.add_secret) secret_q <= sec_c;
    if (cmd_i.load_out) begin
      out_secret_q <= (cmd_i.status == STATUS_OK) ? secret_q : '0;
      out_status_q <= cmd_i.status;
    end
  end

  assign sts_o.mul_done = mul_done;
  assign sts_o.x_eq     = (x_rd_q == xi_q);
  assign sts_o.exp_bit  = exp_v[exp_idx_i];
  assign sts_o.is_last  = in_last_q;
  assign secret_o       = out_secret_q;
  assign status_o       = out_status_q;
endmodule

[rtl/ssr_ctrl.sv]
// Sequencer for share loading, duplicate check and Lagrange interpolation.
module ssr_ctrl #(
  parameter int MAX_SHARES = ssr_pkg::MAX_SHARES_DEF,
  parameter int FIELD_BITS = ssr_pkg::FIELD_BITS_DEF,
  localparam int AW = $clog2(MAX_SHARES),
  localparam int KIW = $clog2(FIELD_BITS)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ssr_pkg::sts_t  sts_i,
  output ssr_pkg::cmd_t  cmd_o,
  output logic [AW-1:0]  wr_addr_o,
  output logic [AW-1:0]  rd_addr_o,
  output logic [KIW-1:0] exp_idx_o
);
  import ssr_pkg::*;

  localparam int CW = $clog2(MAX_SHARES + 1);
  localparam int KW = $clog2(FIELD_BITS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_RED_X, S_RED_Y, S_RED_END, S_CHK_LAST, S_MUL_WAIT, S_EVAL,
    S_DUP_RI, S_DUP_LI, S_DUP_RJ, S_DUP_CJ, S_INT_START, S_INT_RI, S_INT_LI,
    S_INT_J, S_INT_LJ, S_MUL_NUM, S_MUL_DEN, S_POW_INIT, S_POW_BIT, S_POW_SQ,
    S_BASIS, S_TERM, S_ACC, S_DONE
  } state_e;

  state_e        state_q, state_d, ret_q, ret_d;
  dest_e         dst_q, dst_d;
  logic [CW-1:0] count_q, count_d, i_q, i_d, j_q, j_d;
  logic [KW-1:0] k_q, k_d;
  logic          ovf_q, ovf_d, out_valid_q, out_valid_d;
  logic [1:0]    status_q, status_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    dst_d       = dst_q;
    count_d     = count_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    ovf_d       = ovf_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.opa   = OP_ONE;
    cmd_o.opb   = OP_ONE;
    cmd_o.wr_dst = DST_NONE;
    cmd_o.status = status_q;
    in_ready_o  = 1'b0;
    rd_addr_o   = i_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          if (count_q < CW'(MAX_SHARES)) begin
            state_d = S_RED_X;
          end else begin
            ovf_d   = 1'b1;
            state_d = S_CHK_LAST;
          end
        end
      end
      S_RED_X: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.opb = OP_IN_X;
        dst_d     = DST_MEM_X;
        ret_d     = S_RED_Y;
        state_d   = S_MUL_WAIT;
      end
      S_RED_Y: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.opb = OP_IN_Y;
        dst_d     = DST_MEM_Y;
        ret_d     = S_RED_END;
        state_d   = S_MUL_WAIT;
      end
      S_RED_END: begin
        count_d = count_q + CW'(1);
        state_d = S_CHK_LAST;
      end
      S_CHK_LAST: begin
        state_d = sts_i.is_last ? S_EVAL : S_IDLE;
      end
      S_MUL_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.wr_dst = dst_q;
          state_d      = ret_q;
        end
      end
      S_EVAL: begin
        status_d = STATUS_OK;
        i_d      = '0;
        if (ovf_q) begin
          status_d = STATUS_OVER;
          state_d  = S_DONE;
        end else if (count_q < CW'(2)) begin
          state_d = S_INT_START;
        end else begin
          state_d = S_DUP_RI;
        end
      end
      // pairwise duplicate search
      S_DUP_RI: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_DUP_LI;
      end
      S_DUP_LI: begin
        cmd_o.ld_xi = 1'b1;
        j_d         = i_q + CW'(1);
        state_d     = S_DUP_RJ;
      end
      S_DUP_RJ: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = j_q[AW-1:0];
        state_d     = S_DUP_CJ;
      end
      S_DUP_CJ: begin
        if (sts_i.x_eq) begin
          status_d = STATUS_DUP;
          state_d  = S_DONE;
        end else if (j_q + CW'(1) == count_q) begin
          if (i_q + CW'(2) == count_q) begin
            state_d = S_INT_START;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = S_DUP_RI;
          end
        end else begin
          j_d     = j_q + CW'(1);
          state_d = S_DUP_RJ;
        end
      end
      // interpolation at zero
      S_INT_START: begin
        cmd_o.clr_secret = 1'b1;
        i_d     = '0;
        state_d = S_INT_RI;
      end
      S_INT_RI: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_INT_LI;
      end
      S_INT_LI: begin
        cmd_o.ld_xi   = 1'b1;
        cmd_o.init_nd = 1'b1;
        j_d     = '0;
        state_d = S_INT_J;
      end
      S_INT_J: begin
        rd_addr_o = j_q[AW-1:0];
        if (j_q == count_q) begin
          state_d = S_POW_INIT;
        end else if (j_q == i_q) begin
          j_d = j_q + CW'(1);
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_INT_LJ;
        end
      end
      S_INT_LJ: begin
        cmd_o.ld_xj = 1'b1;
        state_d     = S_MUL_NUM;
      end
      S_MUL_NUM: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.opa = OP_NUM;
        cmd_o.opb = OP_XJ;
        dst_d     = DST_NUM;
        ret_d     = S_MUL_DEN;
        state_d   = S_MUL_WAIT;
      end
      S_MUL_DEN: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.opa = OP_DEN;
        cmd_o.opb = OP_DIFF;
        dst_d     = DST_DEN;
        ret_d     = S_INT_J;
        j_d       = j_q + CW'(1);
        state_d   = S_MUL_WAIT;
      end
      // den^(m-2) by square and multiply, LSB first
      S_POW_INIT: begin
        cmd_o.init_pow = 1'b1;
        k_d     = '0;
        state_d = S_POW_BIT;
      end
      S_POW_BIT: begin
        if (k_q == KW'(FIELD_BITS)) begin
          state_d = S_BASIS;
        end else if (sts_i.exp_bit) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.opa = OP_R;
          cmd_o.opb = OP_BASE;
          dst_d     = DST_R;
          ret_d     = S_POW_SQ;
          state_d   = S_MUL_WAIT;
        end else begin
          state_d = S_POW_SQ;
        end
      end
      S_POW_SQ: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.opa = OP_BASE;
        cmd_o.opb = OP_BASE;
        dst_d     = DST_BASE;
        ret_d     = S_POW_BIT;
        k_d       = k_q + KW'(1);
        state_d   = S_MUL_WAIT;
      end
      S_BASIS: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.opa = OP_NUM;
        cmd_o.opb = OP_R;
        dst_d     = DST_NUM;
        ret_d     = S_TERM;
        state_d   = S_MUL_WAIT;
      end
      S_TERM: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.opa = OP_YI;
        cmd_o.opb = OP_NUM;
        dst_d     = DST_T;
        ret_d     = S_ACC;
        state_d   = S_MUL_WAIT;
      end
      S_ACC: begin
        cmd_o.add_secret = 1'b1;
        if (i_q + CW'(1) == count_q) begin
          state_d = S_DONE;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_INT_RI;
        end
      end
      // hand result to the output register, start an empty set
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          count_d        = '0;
          ovf_d          = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      dst_q       <= DST_NONE;
      count_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      ovf_q       <= 1'b0;
      status_q    <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      dst_q       <= dst_d;
      count_q     <= count_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      ovf_q       <= ovf_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign wr_addr_o   = count_q[AW-1:0];
  assign exp_idx_o   = k_q[KIW-1:0];
endmodule

[rtl/shamir_secret_reconstruction.sv]
// Top level of the Shamir secret reconstruction block.
// Shares arrive one per transfer and are reduced modulo the configured prime by a shared
// bit-serial modular multiplier, so a new share is taken only once the previous one is stored.
// The share marked last starts Lagrange interpolation at zero over the n stored shares:
// a pairwise duplicate search, then per share 2*(n-1) multiplications for numerator and
// denominator, one inverse by square and multiply (up to 2*FIELD_BITS multiplications)
// and two more, all in that one multiplier.
// The result sits in an output register, so the next set can load while it waits.
// Status 2 means shares were dropped past MAX_SHARES, 1 duplicate x; the secret is then 0.
// The modulus register lies at address 0 and resets to 2^31-1; values below 3 act as 3.
module shamir_secret_reconstruction #(
  parameter int MAX_SHARES = ssr_pkg::MAX_SHARES_DEF,
  parameter int FIELD_BITS = ssr_pkg::FIELD_BITS_DEF,
  localparam int DW = (FIELD_BITS > 32) ? 64 : 32,
  localparam int PAW = (FIELD_BITS > 32) ? 4 : 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [DW-1:0]  pwdata,
  output logic [DW-1:0]  prdata,
  output logic           pready,
  share_if.sink          share_in,
  result_if.source       result_out
);
  import ssr_pkg::*;

  localparam int AW = $clog2(MAX_SHARES);
  localparam int KIW = $clog2(FIELD_BITS);

  logic [FIELD_BITS-1:0] modulus_q, m_act;
  cmd_t                  cmd;
  sts_t                  sts;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [KIW-1:0]        exp_idx;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET[FIELD_BITS-1:0];
    end else if (psel && penable && pwrite && !paddr[PAW-1]) begin
      modulus_q <= pwdata[FIELD_BITS-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[PAW-1] ? '0 : DW'(modulus_q);
  assign m_act  = (modulus_q < FIELD_BITS'(3)) ? FIELD_BITS'(3) : modulus_q;

  ssr_ctrl #(.MAX_SHARES(MAX_SHARES), .FIELD_BITS(FIELD_BITS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (share_in.valid),
    .in_ready_o (share_in.ready),
    .out_valid_o(result_out.valid),
    .out_ready_i(result_out.ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr),
    .exp_idx_o  (exp_idx)
  );

  ssr_datapath #(.MAX_SHARES(MAX_SHARES), .FIELD_BITS(FIELD_BITS)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .wr_addr_i(wr_addr),
    .rd_addr_i(rd_addr),
    .exp_idx_i(exp_idx),
    .modulus_i(m_act),
    .in_x_i   (share_in.share_x),
    .in_y_i   (share_in.share_y),
    .in_last_i(share_in.is_last),
    .sts_o    (sts),
    .secret_o (result_out.secret),
    .status_o (result_out.status)
  );
endmodule

[rtl/ssr_checker.sv]
// Port-level assertions for the Shamir secret reconstruction block, with bind.
module ssr_checker #(
  parameter int FIELD_BITS = ssr_pkg::FIELD_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [FIELD_BITS-1:0] secret,
  input logic [1:0]            status
);
  import ssr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(secret) && $stable(status))
    else $error("stalled result changed");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (status == STATUS_OK || status == STATUS_DUP || status == STATUS_OVER))
    else $error("undefined status code");

  // error results carry a zero secret
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != STATUS_OK |-> secret == '0)
    else $error("error result with nonzero secret");

  // a share transfer keeps the block busy for at least the next cycle
  a_busy_after_share: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("share taken in back-to-back cycles");
endmodule

bind shamir_secret_reconstruction ssr_checker #(.FIELD_BITS(FIELD_BITS)) u_ssr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (share_in.valid),
  .in_ready (share_in.ready),
  .out_valid(result_out.valid),
  .out_ready(result_out.ready),
  .secret   (result_out.secret),
  .status   (result_out.status)
);

[verif/tb_shamir_secret_reconstruction.sv]
// Testbench for the Shamir secret reconstruction block: share sets in, secrets checked.
module tb_shamir_secret_reconstruction;
  timeunit 1ns;
  timeprecision 1ps;

  import ssr_pkg::*;

  localparam int NSTORE = MAX_SHARES_DEF;
  localparam int FBITS = FIELD_BITS_DEF;
  localparam logic [2:0] ADDR_MODULUS = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1590;

  // kinds of share sets
  localparam int SET_WELL = 0;
  localparam int SET_DUP = 1;
  localparam int SET_OVER = 2;
  localparam int SET_NOISE = 3;

  typedef struct packed {
    logic [FBITS-1:0] secret;
    logic [1:0]       status;
  } secret_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  share_if #(.FW(FBITS)) share_ch ();
  result_if #(.FW(FBITS)) result_ch ();

  shamir_secret_reconstruction u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .share_in   (share_ch),
    .result_out (result_ch)
  );

  // predictor state
  longint unsigned field_mod;
  longint unsigned x_held[NSTORE];
  longint unsigned y_held[NSTORE];
  int              held_count;
  bit              dropped;
  secret_t         secret_q[$];

  int  errors;
  int  shares_sent;
  int  idle_cycles;
  bit  burst_mode;
  int  hold_request;
  int  hold_cnt;
  int  stall_cnt;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                             longint unsigned m);
    return ((a % m) * (b % m)) % m;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                             longint unsigned m);
    longint unsigned r;
    r = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, b, m);
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic longint unsigned live_mod();
    return (field_mod < 3) ? 64'd3 : field_mod;
  endfunction

  // store one accepted share; on the last one interpolate at zero
  task automatic predict_share(logic [FBITS-1:0] x, logic [FBITS-1:0] y, logic last);
    longint unsigned m, acc, basis, diff;
    logic [1:0] st;
    secret_t r;
    m = live_mod();
    if (held_count < NSTORE) begin
      x_held[held_count] = longint'(x) % m;
      y_held[held_count] = longint'(y) % m;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      st = STATUS_OK;
      acc = 0;
      if (dropped) st = STATUS_OVER;
      else begin
        for (int i = 0; i < held_count; i++)
          for (int j = i + 1; j < held_count; j++)
            if (x_held[i] == x_held[j]) st = STATUS_DUP;
      end
      if (st == STATUS_OK) begin
        for (int i = 0; i < held_count; i++) begin
          basis = 1 % m;
          for (int j = 0; j < held_count; j++) begin
            if (j != i) begin
              diff = (x_held[j] + m - x_held[i]) % m;
              basis = mul_mod(basis, mul_mod(x_held[j], pow_mod(diff, m - 2, m), m), m);
            end
          end
          acc = (acc + mul_mod(y_held[i], basis, m)) % m;
        end
      end
      r.secret = acc[FBITS-1:0];
      r.status = st;
      secret_q.push_back(r);
      held_count = 0;
      dropped = 1'b0;
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one share and wait for its transfer
  task automatic send_share(logic [FBITS-1:0] x, logic [FBITS-1:0] y, logic last);
    int gap;
    share_ch.valid   <= 1'b1;
    share_ch.share_x <= x;
    share_ch.share_y <= y;
    share_ch.is_last <= last;
    do @(posedge clk_i); while (!share_ch.ready);
    predict_share(x, y, last);
    shares_sent++;
    gap = gap_len();
    if (gap > 0) begin
      share_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // APB write: setup then access
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_MODULUS) field_mod = longint'(data[FBITS-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    share_ch.valid <= 1'b0;
    while (secret_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [FBITS-1:0] rand_field();
    return FBITS'($urandom());
  endfunction

  // one set of shares of the given kind and size
  task automatic send_set(int kind, int n);
    logic [FBITS-1:0] xs[$];
    logic [FBITS-1:0] cand;
    longint unsigned m;
    bit clash;
    int k;
    m = live_mod();
    if (kind == SET_WELL && n > m) n = int'(m);
    while (xs.size() < n) begin
      cand = rand_field();
      if (m < 64 && $urandom_range(0, 1)) cand = FBITS'($urandom_range(0, 3 * m));
      clash = 1'b0;
      if (kind == SET_WELL)
        foreach (xs[i]) if (longint'(xs[i]) % m == longint'(cand) % m) clash = 1'b1;
      if (!clash) xs.push_back(cand);
    end
    if (kind == SET_DUP && n >= 2) begin
      k = $urandom_range(1, n - 1);
      xs[k] = xs[$urandom_range(0, k - 1)];
      // equal only after reduction, where the sum still fits
      if ($urandom_range(0, 1) && longint'(xs[k]) + m < (64'd1 << FBITS))
        xs[k] = FBITS'(longint'(xs[k]) + m);
    end
    foreach (xs[i]) send_share(xs[i], rand_field(), i == n - 1);
  endtask

  // result checker
  always @(posedge clk_i) begin
    secret_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (secret_q.size() == 0) begin
        $error("unexpected result: secret %0d status %0d", result_ch.secret, result_ch.status);
        errors++;
      end else begin
        want = secret_q.pop_front();
        if (result_ch.secret !== want.secret) begin
          $error("secret: expected %0d, actual %0d", want.secret, result_ch.secret);
          errors++;
        end
        if (result_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, result_ch.status);
          errors++;
        end
      end
    end
  end

  // receiver ready: random stalls, long stalls, and a requested hold-off
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_cnt = hold_request;
      hold_request = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      result_ch.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      result_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 299) == 0) begin
      stall_cnt = $urandom_range(20, 80);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= burst_mode || ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((share_ch.valid && share_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    // single share, extremes of the fields
    send_share('0, '1, 1'b1);
    // three shares, one x at the modulus
    send_share(31'h7FFF_FFFF, 31'h7FFF_FFFE, 1'b0);
    send_share(31'h7FFF_FFFE, 31'd0, 1'b0);
    send_share(31'd1, 31'd12345, 1'b1);
    // duplicate x
    send_share(31'd5, 31'd9, 1'b0);
    send_share(31'd5, 31'd3, 1'b1);
    // store overflow with a duplicate inside: overflow wins
    for (int i = 0; i < 17; i++) send_share(31'(i % 15), rand_field(), i == 16);
    wait_drained();
  endtask

  task automatic test_modulus_settings();
    logic [31:0] mods[10];
    mods = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd15, 32'd251, 32'd65521,
             32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    reg_write(ADDR_UNUSED, 32'd7);
    foreach (mods[i]) begin
      reg_write(mods[i] == 32'd65521 ? ADDR_MODULUS : ADDR_MODULUS, mods[i]);
      repeat (6) send_set($urandom_range(0, 3) == 0 ? SET_DUP : SET_WELL, $urandom_range(1, 4));
      wait_drained();
    end
    // one full store without overflow
    send_set(SET_WELL, NSTORE);
    wait_drained();
  endtask

  task automatic test_random();
    int r, n;
    while (shares_sent < RANDOM_ITEMS + 60) begin
      r = $urandom_range(0, 99);
      burst_mode = ($urandom_range(0, 19) == 0);
      if (r < 70) begin
        n = ($urandom_range(0, 29) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        send_set(SET_WELL, n);
      end else if (r < 84) send_set(SET_DUP, $urandom_range(2, 6));
      else if (r < 92) send_set(SET_OVER, $urandom_range(17, 20));
      else send_set(SET_NOISE, $urandom_range(1, 6));
      if ($urandom_range(0, 149) == 0) begin
        wait_drained();
        reg_write(ADDR_MODULUS, $urandom_range(0, 1) ? 32'h7FFF_FFFF : $urandom_range(3, 1000));
      end
    end
    burst_mode = 1'b0;
    wait_drained();
    reg_write(ADDR_MODULUS, 32'h7FFF_FFFF);
  endtask

  task automatic test_backpressure();
    hold_request = 30000;
    burst_mode = 1'b1;
    repeat (5) send_set(SET_WELL, 2);
    repeat (4) send_set(SET_DUP, 3);
    burst_mode = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    share_ch.valid = 1'b0;
    share_ch.share_x = '0;
    share_ch.share_y = '0;
    share_ch.is_last = 1'b0;
    result_ch.ready = 1'b0;
    field_mod = MODULUS_RESET;
    held_count = 0;
    dropped = 1'b0;
    errors = 0;
    shares_sent = 0;
    idle_cycles = 0;
    burst_mode = 1'b0;
    hold_request = 0;
    hold_cnt = 0;
    stall_cnt = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_modulus_settings();
    test_backpressure();
    test_random();

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
